// ===== src/lzmc_pkg.sv =====
// ----------------------------------------------------------------------------
// lzmc_pkg
// Shared constants, code tables and window port types of the LZ77 match copy
// decoder.
// ----------------------------------------------------------------------------
package lzmc_pkg;

  localparam int WINDOW_BYTES = 32768;
  localparam int LANES        = 8;
  localparam int WIN_AW       = $clog2(WINDOW_BYTES);
  localparam int LANE_AW      = $clog2(LANES);
  localparam int ROW_AW       = WIN_AW - LANE_AW;
  localparam int BANK_AW      = ROW_AW - 1;
  localparam int BANK_DEPTH   = 1 << BANK_AW;
  localparam int NEAR_SPAN    = 2 * LANES;

  localparam logic [8:0] SYM_EOB       = 9'd256;
  localparam logic [8:0] SYM_LEN_FIRST = 9'd257;
  localparam logic [8:0] SYM_LEN_LAST  = 9'd285;
  localparam logic [4:0] DSYM_LAST     = 5'd29;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EOB      = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_FAR      = 3'd3;
  localparam logic [2:0] ST_ILLEGAL  = 3'd4;

  typedef struct packed {
    logic              en;
    logic [WIN_AW-1:0] addr;
  } win_rd_t;

  typedef struct packed {
    logic                 en;
    logic [WIN_AW-1:0]    addr;
    logic [8*LANES-1:0]   data;
    logic [LANE_AW:0]     count;
  } win_wr_t;

  function automatic logic [8:0] len_base(input logic [4:0] idx);
    logic [8:0] v;
    case (idx)
      5'd0:  v = 9'd3;
      5'd1:  v = 9'd4;
      5'd2:  v = 9'd5;
      5'd3:  v = 9'd6;
      5'd4:  v = 9'd7;
      5'd5:  v = 9'd8;
      5'd6:  v = 9'd9;
      5'd7:  v = 9'd10;
      5'd8:  v = 9'd11;
      5'd9:  v = 9'd13;
      5'd10: v = 9'd15;
      5'd11: v = 9'd17;
      5'd12: v = 9'd19;
      5'd13: v = 9'd23;
      5'd14: v = 9'd27;
      5'd15: v = 9'd31;
      5'd16: v = 9'd35;
      5'd17: v = 9'd43;
      5'd18: v = 9'd51;
      5'd19: v = 9'd59;
      5'd20: v = 9'd67;
      5'd21: v = 9'd83;
      5'd22: v = 9'd99;
      5'd23: v = 9'd115;
      5'd24: v = 9'd131;
      5'd25: v = 9'd163;
      5'd26: v = 9'd195;
      5'd27: v = 9'd227;
      5'd28: v = 9'd258;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] len_bits(input logic [4:0] idx);
    logic [2:0] v;
    if (idx >= 5'd8 && idx <= 5'd27) begin
      v = 3'((idx - 5'd4) >> 2);
    end else begin
      v = 3'd0;
    end
    return v;
  endfunction

  function automatic logic [15:0] dist_base(input logic [4:0] idx);
    logic [15:0] v;
    case (idx)
      5'd0:  v = 16'd1;
      5'd1:  v = 16'd2;
      5'd2:  v = 16'd3;
      5'd3:  v = 16'd4;
      5'd4:  v = 16'd5;
      5'd5:  v = 16'd7;
      5'd6:  v = 16'd9;
      5'd7:  v = 16'd13;
      5'd8:  v = 16'd17;
      5'd9:  v = 16'd25;
      5'd10: v = 16'd33;
      5'd11: v = 16'd49;
      5'd12: v = 16'd65;
      5'd13: v = 16'd97;
      5'd14: v = 16'd129;
      5'd15: v = 16'd193;
      5'd16: v = 16'd257;
      5'd17: v = 16'd385;
      5'd18: v = 16'd513;
      5'd19: v = 16'd769;
      5'd20: v = 16'd1025;
      5'd21: v = 16'd1537;
      5'd22: v = 16'd2049;
      5'd23: v = 16'd3073;
      5'd24: v = 16'd4097;
      5'd25: v = 16'd6145;
      5'd26: v = 16'd8193;
      5'd27: v = 16'd12289;
      5'd28: v = 16'd16385;
      5'd29: v = 16'd24577;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] dist_bits(input logic [4:0] idx);
    logic [3:0] v;
    if (idx >= 5'd4 && idx <= 5'd29) begin
      v = 4'((idx - 5'd2) >> 1);
    end else begin
      v = 4'd0;
    end
    return v;
  endfunction

endpackage

// ===== src/lz77_match_copy_decoder.sv =====
// ----------------------------------------------------------------------------
// lz77_match_copy_decoder
// Back end of a DEFLATE decompressor: literals, end of block and back
// reference copies through a 32 KiB history window, with sticky errors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one decoded symbol item (or a
//   new-stream marker when kind is 1). Output channel out_valid/out_ready
//   carries result items of up to 8 bytes, first byte in data[7:0].
//   cfg_we/cfg_wdata writes output_limit.
//   Timing: a new-stream item is taken in the idle state. Any other item
//   passes the decode, sum and check states after its transfer; a literal,
//   end of block or error then gives its one result once the output is free.
//   A match of length L gives ceil(L/8) results, one per cycle while the
//   receiver does not stall, each read through the window read register;
//   the input stays busy until the last of them.
//   The next item is accepted as soon as the last result is in the output
//   register, while that result still waits for the receiver.
//   A stalled receiver holds the copy in place; nothing is lost.
//   Reset clears the byte count, the error and the output valid flag and sets
//   output_limit to all ones. The window needs no clearing pass.
// ----------------------------------------------------------------------------
module lz77_match_copy_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [8:0]  symbol,
  input  logic [4:0]  length_extra,
  input  logic [4:0]  distance_symbol,
  input  logic [12:0] distance_extra,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] data,
  output logic [3:0]  byte_count,
  output logic        last,
  output logic [2:0]  status,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SUM    = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_COPY   = 3'd4;

  localparam int AW = lzmc_pkg::WIN_AW;

  logic [2:0]   state;
  logic [31:0]  count;
  logic [2:0]   err;
  logic [31:0]  limit;
  logic         b_valid;
  logic [8:0]   iss_rem;

  logic [8:0]   sym_q;
  logic [4:0]   lext_q;
  logic [4:0]   dsym_q;
  logic [12:0]  dext_q;
  logic [8:0]   len_q;
  logic [15:0]  dist_q;
  logic         full_q;
  logic [32:0]  sum_q;
  logic         far_q;
  logic         near_q;
  logic [3:0]   near_idx [lzmc_pkg::LANES];
  logic [AW-1:0] src_ptr;
  logic [3:0]   b_n;
  logic         b_last;
  logic [127:0] tail;

  logic         ld;
  logic         accept;
  logic [4:0]   li;
  logic [8:0]   len_calc;
  logic [15:0]  dist_calc;
  logic [3:0]   near_calc [lzmc_pkg::LANES];
  logic         illegal;
  logic         over;
  logic [2:0]   chk_status;
  logic         chk_set_err;
  logic         chk_literal;
  logic         chk_copy;
  logic         chk_fire;
  logic         b_fire;
  logic         iss;
  logic [3:0]   n_iss;
  logic [63:0]  win_data;
  logic [63:0]  chunk;
  logic [63:0]  new_bytes;
  logic [3:0]   new_n;
  logic         tail_we;
  logic [191:0] tail_cat;
  logic [127:0] tail_next;

  lzmc_pkg::win_rd_t rd;
  lzmc_pkg::win_wr_t wr;

  lzmc_window u_window (
    .clk     (clk),
    .rd      (rd),
    .wr      (wr),
    .rd_data (win_data)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign ld       = !out_valid || out_ready;

  // length and distance from code tables
  assign li        = 5'(sym_q - lzmc_pkg::SYM_LEN_FIRST);
  assign len_calc  = lzmc_pkg::len_base(li)
                     + 9'(lext_q & 5'((6'd1 << lzmc_pkg::len_bits(li)) - 6'd1));
  assign dist_calc = lzmc_pkg::dist_base(dsym_q)
                     + 16'(dext_q & 13'((14'd1 << lzmc_pkg::dist_bits(dsym_q)) - 14'd1));

  // byte j of a near copy repeats the last d bytes with period d
  always_comb begin
    logic [4:0] m;
    logic [4:0] d;
    d = dist_q[4:0];
    for (int j = 0; j < lzmc_pkg::LANES; j++) begin
      m = 5'(j);
      for (int k = 0; k < lzmc_pkg::LANES - 1; k++) begin
        if (m >= d) begin
          m = m - d;
        end
      end
      near_calc[j] = 4'(5'(lzmc_pkg::NEAR_SPAN) - d + m);
    end
  end

  assign illegal = (sym_q > lzmc_pkg::SYM_LEN_LAST) || (dsym_q > lzmc_pkg::DSYM_LAST);
  assign over    = sum_q > {1'b0, limit};

  always_comb begin
    chk_status  = lzmc_pkg::ST_OK;
    chk_set_err = 1'b0;
    chk_literal = 1'b0;
    chk_copy    = 1'b0;
    if (err != lzmc_pkg::ST_OK) begin
      chk_status = err;
    end else if (sym_q == lzmc_pkg::SYM_EOB) begin
      chk_status = lzmc_pkg::ST_EOB;
    end else if (full_q) begin
      chk_status  = lzmc_pkg::ST_OVERFLOW;
      chk_set_err = 1'b1;
    end else if (sym_q < lzmc_pkg::SYM_EOB) begin
      chk_literal = 1'b1;
    end else if (illegal) begin
      chk_status  = lzmc_pkg::ST_ILLEGAL;
      chk_set_err = 1'b1;
    end else if (far_q) begin
      chk_status  = lzmc_pkg::ST_FAR;
      chk_set_err = 1'b1;
    end else if (over) begin
      chk_status  = lzmc_pkg::ST_OVERFLOW;
      chk_set_err = 1'b1;
    end else begin
      chk_copy = 1'b1;
    end
  end

  assign chk_fire = (state == S_CHECK) && ld && !chk_copy;

  // copy engine: issue a window read, then form and write back the chunk
  assign b_fire = (state == S_COPY) && b_valid && ld;
  assign iss    = (state == S_COPY) && (iss_rem != 9'd0) && (!b_valid || b_fire);
  assign n_iss  = (iss_rem >= 9'(lzmc_pkg::LANES)) ? 4'(lzmc_pkg::LANES) : iss_rem[3:0];

  always_comb begin
    logic [7:0] b;
    for (int j = 0; j < lzmc_pkg::LANES; j++) begin
      b = near_q ? tail[{near_idx[j], 3'b000} +: 8] : win_data[8*j +: 8];
      chunk[8*j +: 8] = (4'(j) < b_n) ? b : 8'h00;
    end
  end

  assign rd.en   = iss;
  assign rd.addr = src_ptr;

  always_comb begin
    if (state == S_COPY) begin
      new_bytes = chunk;
      new_n     = b_n;
      tail_we   = b_fire;
    end else begin
      new_bytes = {56'd0, sym_q[7:0]};
      new_n     = 4'd1;
      tail_we   = chk_fire && chk_literal;
    end
  end

  assign wr.en    = tail_we;
  assign wr.addr  = count[AW-1:0];
  assign wr.data  = new_bytes;
  assign wr.count = new_n;

  assign tail_cat  = {new_bytes, tail};
  assign tail_next = tail_cat[{new_n, 3'b000} +: 128];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= 32'd0;
      err       <= lzmc_pkg::ST_OK;
      limit     <= 32'hFFFF_FFFF;
      out_valid <= 1'b0;
      b_valid   <= 1'b0;
      iss_rem   <= 9'd0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      if (out_valid && out_ready && !chk_fire && !b_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (kind) begin
              count <= 32'd0;
              err   <= lzmc_pkg::ST_OK;
            end else begin
              state <= S_DECODE;
            end
          end
        end
        S_DECODE: begin
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (ld) begin
            if (chk_copy) begin
              state   <= S_COPY;
              iss_rem <= len_q;
              b_valid <= 1'b0;
            end else begin
              state     <= S_IDLE;
              out_valid <= 1'b1;
              if (chk_set_err) begin
                err <= chk_status;
              end
              if (chk_literal) begin
                count <= count + 32'd1;
              end
            end
          end
        end
        S_COPY: begin
          if (b_fire) begin
            count     <= count + 32'(b_n);
            out_valid <= 1'b1;
            if (b_last) begin
              state <= S_IDLE;
            end
          end
          if (iss) begin
            iss_rem <= iss_rem - 9'(n_iss);
            b_valid <= 1'b1;
          end else if (b_fire) begin
            b_valid <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sym_q  <= symbol;
      lext_q <= length_extra;
      dsym_q <= distance_symbol;
      dext_q <= distance_extra;
    end
    if (state == S_DECODE) begin
      len_q  <= len_calc;
      dist_q <= dist_calc;
      full_q <= count >= limit;
    end
    if (state == S_SUM) begin
      sum_q    <= {1'b0, count} + 33'(len_q);
      far_q    <= 32'(dist_q) > count;
      near_q   <= dist_q <= 16'(lzmc_pkg::NEAR_SPAN);
      near_idx <= near_calc;
    end
    if (state == S_CHECK && ld && chk_copy) begin
      src_ptr <= count[AW-1:0] - dist_q[AW-1:0];
    end
    if (iss) begin
      src_ptr <= src_ptr + AW'(lzmc_pkg::LANES);
      b_n     <= n_iss;
      b_last  <= iss_rem <= 9'(lzmc_pkg::LANES);
    end
    if (tail_we) begin
      tail <= tail_next;
    end
    if (chk_fire) begin
      data       <= chk_literal ? {56'd0, sym_q[7:0]} : 64'd0;
      byte_count <= chk_literal ? 4'd1 : 4'd0;
      last       <= 1'b1;
      status     <= chk_status;
    end else if (b_fire) begin
      data       <= chunk;
      byte_count <= b_n;
      last       <= b_last;
      status     <= lzmc_pkg::ST_OK;
    end
  end

  // chunk stage only holds work during a copy
  a_bvalid_copy : assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (state == S_COPY))
    else $error("copy chunk pending outside copy");

  // errors stay until a new stream starts
  a_err_sticky : assert property (@(posedge clk) disable iff (rst)
    (err != lzmc_pkg::ST_OK) && !(accept && kind) |=> (err == $past(err)))
    else $error("sticky error changed");

  // every window write carries between one and eight bytes
  a_wr_count : assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (wr.count != 4'd0) && (wr.count <= 4'(lzmc_pkg::LANES)))
    else $error("bad window write size");

  // the last chunk leaves nothing to issue
  a_last_rem : assert property (@(posedge clk) disable iff (rst)
    b_valid && b_last |-> (iss_rem == 9'd0))
    else $error("bytes left after last chunk");

endmodule

// ===== src/lzmc_window.sv =====
// ----------------------------------------------------------------------------
// lzmc_window
// History window held as two banks of 8-byte rows (even rows, odd rows).
// Reads cover 8 consecutive bytes and writes up to 8 at any byte address.
// ----------------------------------------------------------------------------
module lzmc_window (
  input  logic                              clk,
  input  lzmc_pkg::win_rd_t                 rd,
  input  lzmc_pkg::win_wr_t                 wr,
  output logic [8*lzmc_pkg::LANES-1:0]      rd_data
);

  logic [8*lzmc_pkg::LANES-1:0] mem_even [lzmc_pkg::BANK_DEPTH];
  logic [8*lzmc_pkg::LANES-1:0] mem_odd  [lzmc_pkg::BANK_DEPTH];

  logic [lzmc_pkg::ROW_AW-1:0]   rd_row;
  logic [lzmc_pkg::ROW_AW-1:0]   wr_row;
  logic [lzmc_pkg::BANK_AW-1:0]  rd_even_addr;
  logic [lzmc_pkg::BANK_AW-1:0]  rd_odd_addr;
  logic [lzmc_pkg::BANK_AW-1:0]  wr_even_addr;
  logic [lzmc_pkg::BANK_AW-1:0]  wr_odd_addr;
  logic [8*lzmc_pkg::LANES-1:0]  even_q;
  logic [8*lzmc_pkg::LANES-1:0]  odd_q;
  logic [lzmc_pkg::LANE_AW-1:0]  off_q;
  logic                          swap_q;
  logic [16*lzmc_pkg::LANES-1:0] pair;
  logic [16*lzmc_pkg::LANES-1:0] wr_data2;
  logic [2*lzmc_pkg::LANES-1:0]  wr_lanes2;
  logic [lzmc_pkg::LANES-1:0]    count_mask;
  logic [lzmc_pkg::LANES-1:0]    even_lanes;
  logic [lzmc_pkg::LANES-1:0]    odd_lanes;
  logic [8*lzmc_pkg::LANES-1:0]  even_wdata;
  logic [8*lzmc_pkg::LANES-1:0]  odd_wdata;

  assign rd_row       = rd.addr[lzmc_pkg::WIN_AW-1:lzmc_pkg::LANE_AW];
  assign rd_odd_addr  = rd_row[lzmc_pkg::ROW_AW-1:1];
  assign rd_even_addr = rd_row[lzmc_pkg::ROW_AW-1:1] + lzmc_pkg::BANK_AW'(rd_row[0]);

  assign wr_row       = wr.addr[lzmc_pkg::WIN_AW-1:lzmc_pkg::LANE_AW];
  assign wr_odd_addr  = wr_row[lzmc_pkg::ROW_AW-1:1];
  assign wr_even_addr = wr_row[lzmc_pkg::ROW_AW-1:1] + lzmc_pkg::BANK_AW'(wr_row[0]);

  always_comb begin
    for (int i = 0; i < lzmc_pkg::LANES; i++) begin
      count_mask[i] = ((lzmc_pkg::LANE_AW+1)'(i) < wr.count);
    end
  end

  assign wr_lanes2 = {{lzmc_pkg::LANES{1'b0}}, count_mask} << wr.addr[lzmc_pkg::LANE_AW-1:0];
  assign wr_data2  = {{(8*lzmc_pkg::LANES){1'b0}}, wr.data}
                     << {wr.addr[lzmc_pkg::LANE_AW-1:0], 3'b000};

  // the low row of a span goes to the bank of its parity, the high row to the other
  assign even_lanes = wr_row[0] ? wr_lanes2[2*lzmc_pkg::LANES-1:lzmc_pkg::LANES]
                                : wr_lanes2[lzmc_pkg::LANES-1:0];
  assign odd_lanes  = wr_row[0] ? wr_lanes2[lzmc_pkg::LANES-1:0]
                                : wr_lanes2[2*lzmc_pkg::LANES-1:lzmc_pkg::LANES];
  assign even_wdata = wr_row[0] ? wr_data2[16*lzmc_pkg::LANES-1:8*lzmc_pkg::LANES]
                                : wr_data2[8*lzmc_pkg::LANES-1:0];
  assign odd_wdata  = wr_row[0] ? wr_data2[8*lzmc_pkg::LANES-1:0]
                                : wr_data2[16*lzmc_pkg::LANES-1:8*lzmc_pkg::LANES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      for (int i = 0; i < lzmc_pkg::LANES; i++) begin
        if (even_lanes[i]) begin
          mem_even[wr_even_addr][8*i +: 8] <= even_wdata[8*i +: 8];
        end
        if (odd_lanes[i]) begin
          mem_odd[wr_odd_addr][8*i +: 8] <= odd_wdata[8*i +: 8];
        end
      end
    end
    if (rd.en) begin
      even_q <= mem_even[rd_even_addr];
      odd_q  <= mem_odd[rd_odd_addr];
      off_q  <= rd.addr[lzmc_pkg::LANE_AW-1:0];
      swap_q <= rd_row[0];
    end
  end

  assign pair    = swap_q ? {even_q, odd_q} : {odd_q, even_q};
  assign rd_data = pair[{off_q, 3'b000} +: 8*lzmc_pkg::LANES];

endmodule

// ===== tb/sv/tb_lz77_match_copy_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_lz77_match_copy_decoder
// Self-checking bench for the LZ77 match copy decoder. A short table of
// directed symbols covers end of block, sticky errors, illegal symbols,
// distances that reach too far and overlapping copies. Random streams follow
// under several output limits (zero, small, all ones), with one long run of
// near-maximal matches that wraps the history window. Every output transfer
// is compared field by field with a bench-side decoder that keeps its own
// window, byte count and error, while both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_lz77_match_copy_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD  = 5;
  localparam int CYCLE_LIMIT  = 600_000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_AFTER   = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam bit FIXED        = 1'b1;
  localparam bit PRED         = 1'b0;

  typedef enum logic {GEN_MIXED, GEN_LONG} gen_mode_t;

  typedef struct {
    logic        kind;
    logic [8:0]  symbol;
    logic [4:0]  lext;
    logic [4:0]  dsym;
    logic [12:0] dext;
  } sym_item_t;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
    logic [2:0]  status;
  } out_word_t;

  typedef struct {
    sym_item_t  item;
    bit         fixed;
    logic [2:0] status;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [8:0]  symbol;
  logic [4:0]  length_extra;
  logic [4:0]  distance_symbol;
  logic [12:0] distance_extra;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] data;
  logic [3:0]  byte_count;
  logic        last;
  logic [2:0]  status;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  // bench-side decoder state
  logic [7:0]  hist [0:lzmc_pkg::WINDOW_BYTES-1];
  logic [31:0] p_count;
  logic [2:0]  p_err;
  logic [31:0] p_limit;
  logic [31:0] peak_count;

  out_word_t expected_words [$];
  dir_row_t  dir_rows [$];

  int n_items;
  int n_out;
  int n_bytes;
  int n_err_out;
  int n_fail;
  int n_cycles;
  int send_burst;
  int recv_burst;

  lz77_match_copy_decoder u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .symbol         (symbol),
    .length_extra   (length_extra),
    .distance_symbol(distance_symbol),
    .distance_extra (distance_extra),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .data           (data),
    .byte_count     (byte_count),
    .last           (last),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int len_bits_of(int li);
    return (li < 8 || li == 28) ? 0 : (li - 4) >> 2;
  endfunction

  function automatic int len_base_of(int li);
    if (li == 28) return 258;
    if (li < 8) return 3 + li;
    return ((4 + (li & 3)) << len_bits_of(li)) + 3;
  endfunction

  function automatic int dist_bits_of(int d);
    return (d < 4) ? 0 : (d - 2) >> 1;
  endfunction

  function automatic int dist_base_of(int d);
    if (d < 4) return d + 1;
    return ((2 + (d & 1)) << dist_bits_of(d)) + 1;
  endfunction

  function automatic void post(logic [63:0] d, int n, bit lst, logic [2:0] st);
    out_word_t w;
    w.data   = d;
    w.nbytes = 4'(n);
    w.last   = lst;
    w.status = st;
    expected_words.push_back(w);
  endfunction

  function automatic void flag(logic [2:0] code);
    p_err = code;
    post(64'd0, 0, 1'b1, code);
  endfunction

  function automatic void keep_byte(logic [7:0] b);
    hist[p_count[lzmc_pkg::WIN_AW-1:0]] = b;
    p_count++;
    if (p_count > peak_count) peak_count = p_count;
  endfunction

  // decodes one symbol item, queues the transfers it should produce
  function automatic void decode_item(sym_item_t it);
    int          li, len, distance, done, nb;
    logic [63:0] w;
    logic [7:0]  b;
    logic [31:0] src;
    if (it.kind) begin
      p_count = 0;
      p_err   = lzmc_pkg::ST_OK;
      return;
    end
    if (p_err != lzmc_pkg::ST_OK) begin
      post(64'd0, 0, 1'b1, p_err);
      return;
    end
    if (it.symbol == lzmc_pkg::SYM_EOB) begin
      post(64'd0, 0, 1'b1, lzmc_pkg::ST_EOB);
      return;
    end
    if (p_count >= p_limit) begin
      flag(lzmc_pkg::ST_OVERFLOW);
      return;
    end
    if (it.symbol < lzmc_pkg::SYM_EOB) begin
      keep_byte(it.symbol[7:0]);
      post(64'(it.symbol), 1, 1'b1, lzmc_pkg::ST_OK);
      return;
    end
    if (it.symbol > lzmc_pkg::SYM_LEN_LAST || it.dsym > lzmc_pkg::DSYM_LAST) begin
      flag(lzmc_pkg::ST_ILLEGAL);
      return;
    end
    li       = int'(it.symbol - lzmc_pkg::SYM_LEN_FIRST);
    len      = len_base_of(li) + (int'(it.lext) & ((1 << len_bits_of(li)) - 1));
    distance = dist_base_of(int'(it.dsym))
             + (int'(it.dext) & ((1 << dist_bits_of(int'(it.dsym))) - 1));
    if (32'(distance) > p_count) begin
      flag(lzmc_pkg::ST_FAR);
      return;
    end
    if ({1'b0, p_count} + 33'(len) > {1'b0, p_limit}) begin
      flag(lzmc_pkg::ST_OVERFLOW);
      return;
    end
    done = 0;
    while (done < len) begin
      w  = '0;
      nb = 0;
      while (nb < lzmc_pkg::LANES && done < len) begin
        src = p_count - 32'(distance);
        b   = hist[src[lzmc_pkg::WIN_AW-1:0]];
        keep_byte(b);
        w[8*nb +: 8] = b;
        nb++;
        done++;
      end
      post(w, nb, done == len, lzmc_pkg::ST_OK);
    end
  endfunction

  function automatic int draw_gap(ref int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  // mostly well-formed symbols with reachable distances, some noise
  function automatic sym_item_t make_item(gen_mode_t mode);
    sym_item_t it;
    int        r, reach, target, d;
    it.kind   = 1'b0;
    it.symbol = 9'($urandom_range(0, 255));
    it.lext   = 5'($urandom);
    it.dsym   = 5'($urandom_range(0, 29));
    it.dext   = 13'($urandom);
    r = $urandom_range(0, 99);
    if (mode == GEN_MIXED && p_err != lzmc_pkg::ST_OK && r < 50) begin
      it.kind   = 1'b1;
      it.symbol = 9'($urandom);
    end else if (mode == GEN_MIXED && r < 4) begin
      it.kind = 1'b1;
    end else if (r < (mode == GEN_LONG ? 1 : 10)) begin
      it.symbol = lzmc_pkg::SYM_EOB;
    end else if (p_count == 0 || r < (mode == GEN_LONG ? 5 : 40)) begin
      it.kind = 1'b0;
    end else if (mode == GEN_LONG || r < 88) begin
      if (mode == GEN_LONG)
        it.symbol = ($urandom_range(0, 19) != 0) ? 9'($urandom_range(283, 285))
                                                 : 9'($urandom_range(257, 285));
      else
        it.symbol = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(269, 285))
                                                : 9'($urandom_range(257, 268));
      reach  = (p_count > lzmc_pkg::WINDOW_BYTES) ? lzmc_pkg::WINDOW_BYTES
                                                  : int'(p_count);
      target = $urandom_range(0, 1) ? $urandom_range(1, reach < 16 ? reach : 16)
                                    : $urandom_range(1, reach);
      d = lzmc_pkg::DSYM_LAST;
      while (dist_base_of(d) > target) d--;
      it.dsym = 5'(d);
      it.dext = (it.dext & ~13'((1 << dist_bits_of(d)) - 1))
              | 13'(target - dist_base_of(d));
    end else begin
      case ($urandom_range(0, 2))
        0: it.symbol = 9'($urandom_range(286, 511));
        1: begin
          it.symbol = 9'($urandom_range(257, 285));
          it.dsym   = 5'($urandom_range(30, 31));
        end
        default: it.symbol = 9'($urandom_range(257, 285));
      endcase
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    n_fail++;
    if (n_fail <= 40)
      $display("mismatch at transfer %0d: %s got %h expected %h", n_out, what, got, want);
  endtask

  task automatic send_item(sym_item_t it, bit fixed, logic [2:0] st);
    int gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind            = it.kind;
    symbol          = it.symbol;
    length_extra    = it.lext;
    distance_symbol = it.dsym;
    distance_extra  = it.dext;
    in_valid        = 1'b1;
    do @(posedge clk); while (!in_ready);
    decode_item(it);
    if (fixed) begin
      void'(expected_words.pop_back());
      post(st == lzmc_pkg::ST_OK ? 64'(it.symbol) : 64'd0,
           st == lzmc_pkg::ST_OK ? 1 : 0, 1'b1, st);
    end
    n_items++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(logic [31:0] v);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we  = 1'b0;
    p_limit = v;
  endtask

  task automatic run_phase(logic [31:0] lim, int count, gen_mode_t mode);
    sym_item_t it;
    drain();
    write_limit(lim);
    it      = make_item(mode);
    it.kind = 1'b1;
    send_item(it, PRED, lzmc_pkg::ST_OK);
    repeat (count) send_item(make_item(mode), PRED, lzmc_pkg::ST_OK);
  endtask

  function automatic void add_row(logic k, logic [8:0] sym, logic [4:0] le,
                                  logic [4:0] ds, logic [12:0] de, bit fx,
                                  logic [2:0] st);
    dir_row_t row;
    row.item.kind   = k;
    row.item.symbol = sym;
    row.item.lext   = le;
    row.item.dsym   = ds;
    row.item.dext   = de;
    row.fixed       = fx;
    row.status      = st;
    dir_rows.push_back(row);
  endfunction

  always @(posedge clk) begin : check_out
    out_word_t w;
    if (!rst && out_valid && out_ready) begin
      n_out++;
      n_bytes += byte_count;
      if (status >= lzmc_pkg::ST_OVERFLOW) n_err_out++;
      if (expected_words.size() == 0) begin
        report_mismatch("transfer with nothing pending", data, 64'd0);
      end else begin
        w = expected_words.pop_front();
        if (data !== w.data) report_mismatch("data", data, w.data);
        if (byte_count !== w.nbytes)
          report_mismatch("byte_count", 64'(byte_count), 64'(w.nbytes));
        if (last !== w.last) report_mismatch("last", 64'(last), 64'(w.last));
        if (status !== w.status)
          report_mismatch("status", 64'(status), 64'(w.status));
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin : receiver
    int stall;
    int hold_left;
    bit hold_done;
    stall     = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        out_ready = 1'b0;
      end else if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (!hold_done && n_out >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready = 1'b0;
      end else if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        stall     = draw_gap(recv_burst);
        out_ready = (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  initial begin : watchdog
    n_cycles = 0;
    while (n_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      n_cycles++;
    end
    $display("timeout after %0d cycles, %0d transfers still pending",
             n_cycles, expected_words.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    rst             = 1'b1;
    in_valid        = 1'b0;
    kind            = 1'b0;
    symbol          = '0;
    length_extra    = '0;
    distance_symbol = '0;
    distance_extra  = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    p_count         = '0;
    p_err           = lzmc_pkg::ST_OK;
    p_limit         = '1;
    peak_count      = '0;
    n_items         = 0;
    n_out           = 0;
    n_bytes         = 0;
    n_err_out       = 0;
    n_fail          = 0;
    send_burst      = 0;
    recv_burst      = 0;

    //       kind sym     lext   dsym   dext       check  status
    add_row(1'b1, 9'd0,   5'd0,  5'd0,  13'd0,     PRED,  lzmc_pkg::ST_OK);
    add_row(1'b0, lzmc_pkg::SYM_EOB, 5'd0, 5'd0, 13'd0, FIXED, lzmc_pkg::ST_EOB);
    add_row(1'b0, 9'd257, 5'd0,  5'd0,  13'd0,     FIXED, lzmc_pkg::ST_FAR);
    add_row(1'b0, 9'h33,  5'd0,  5'd0,  13'd0,     FIXED, lzmc_pkg::ST_FAR);
    add_row(1'b0, lzmc_pkg::SYM_EOB, 5'd0, 5'd0, 13'd0, FIXED, lzmc_pkg::ST_FAR);
    add_row(1'b1, 9'd511, 5'd31, 5'd31, 13'h1FFF,  PRED,  lzmc_pkg::ST_OK);
    add_row(1'b0, 9'd0,   5'd0,  5'd0,  13'd0,     FIXED, lzmc_pkg::ST_OK);
    add_row(1'b0, 9'd255, 5'd31, 5'd31, 13'h1FFF,  FIXED, lzmc_pkg::ST_OK);
    add_row(1'b0, 9'h5A,  5'd0,  5'd0,  13'd0,     FIXED, lzmc_pkg::ST_OK);
    // overlapping copies at distance 1, 4 and 3, then a copy at distance 512
    add_row(1'b0, 9'd257, 5'd31, 5'd0,  13'h1FFF,  PRED,  lzmc_pkg::ST_OK);
    add_row(1'b0, 9'd285, 5'd31, 5'd3,  13'h1FFF,  PRED,  lzmc_pkg::ST_OK);
    add_row(1'b0, 9'd284, 5'd31, 5'd2,  13'h0,     PRED,  lzmc_pkg::ST_OK);
    add_row(1'b0, 9'd264, 5'd0,  5'd17, 13'h007F,  PRED,  lzmc_pkg::ST_OK);
    // distance equal to the byte count, then one past it
    add_row(1'b0, 9'd268, 5'd1,  5'd18, 13'd19,    PRED,  lzmc_pkg::ST_OK);
    add_row(1'b0, 9'd270, 5'd3,  5'd18, 13'd38,    FIXED, lzmc_pkg::ST_FAR);
    add_row(1'b1, 9'd0,   5'd0,  5'd0,  13'd0,     PRED,  lzmc_pkg::ST_OK);
    add_row(1'b0, 9'd286, 5'd0,  5'd0,  13'd0,     FIXED, lzmc_pkg::ST_ILLEGAL);
    add_row(1'b1, 9'd0,   5'd0,  5'd0,  13'd0,     PRED,  lzmc_pkg::ST_OK);
    add_row(1'b0, 9'd511, 5'd31, 5'd31, 13'h1FFF,  FIXED, lzmc_pkg::ST_ILLEGAL);
    add_row(1'b1, 9'd0,   5'd0,  5'd0,  13'd0,     PRED,  lzmc_pkg::ST_OK);
    add_row(1'b0, 9'h80,  5'd0,  5'd0,  13'd0,     FIXED, lzmc_pkg::ST_OK);
    add_row(1'b0, 9'd257, 5'd0,  5'd30, 13'd0,     FIXED, lzmc_pkg::ST_ILLEGAL);
    add_row(1'b1, 9'd0,   5'd0,  5'd0,  13'd0,     PRED,  lzmc_pkg::ST_OK);
    add_row(1'b0, 9'd285, 5'd0,  5'd29, 13'h1FFF,  FIXED, lzmc_pkg::ST_FAR);
    add_row(1'b1, 9'd0,   5'd0,  5'd0,  13'd0,     PRED,  lzmc_pkg::ST_OK);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].status);

    run_phase(32'h0, 8, GEN_MIXED);
    run_phase(32'($urandom_range(30, 300)), 20, GEN_MIXED);
    run_phase(32'hFFFF_FFFF, 160, GEN_LONG);
    run_phase(32'($urandom_range(300, 3000)), 15, GEN_MIXED);
    drain();

    $display("run: %0d items in, %0d transfers out, %0d bytes, %0d error responses",
             n_items, n_out, n_bytes, n_err_out);
    $display("limits from zero to all ones, longest stream %0d bytes (window %0d), %0d cycles",
             peak_count, lzmc_pkg::WINDOW_BYTES, n_cycles);
    if (n_fail == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
src/lzmc_pkg.sv
src/lzmc_window.sv
src/lz77_match_copy_decoder.sv
tb/sv/tb_lz77_match_copy_decoder.sv
